@@ design/mmc_pkg.sv @@
`default_nettype none
package mmc_pkg;

    // configuration port
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int LEN_W      = 6;

    localparam logic [CFG_IDX_W-1:0] REG_LIMB_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEG_INV    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_A_LENGTH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B_LENGTH   = 2'd3;

    // sequencer to cell row
    typedef struct packed {
        logic load;     // write load data into the selected cell
        logic rot_an;   // rotate a and n rings one place toward cell 0
        logic rot_t;    // rotate the T ring, tail takes new_t
        logic clear_t;  // zero the T ring
    } mmc_ctl_t;

endpackage
`default_nettype wire

@@ design/mmc_in_if.sv @@
`default_nettype none
interface mmc_in_if #(
    parameter int W = 32
);
    logic         valid;
    logic         ready;
    logic [W-1:0] a_limb;
    logic [W-1:0] b_limb;
    logic [W-1:0] mod_limb;

    modport source (output valid, a_limb, b_limb, mod_limb, input ready);
    modport sink   (input valid, a_limb, b_limb, mod_limb, output ready);
endinterface
`default_nettype wire

@@ design/mmc_out_if.sv @@
`default_nettype none
interface mmc_out_if #(
    parameter int W = 32
);
    logic         valid;
    logic         ready;
    logic [W-1:0] result_limb;
    logic         last;

    modport source (output valid, result_limb, last, input ready);
    modport sink   (input valid, result_limb, last, output ready);
endinterface
`default_nettype wire

@@ design/mmc_cell.sv @@
`default_nettype none
module mmc_cell #(
    parameter int W = 32
) (
    input  wire logic             clk,
    input  wire mmc_pkg::mmc_ctl_t ctl,
    input  wire logic             sel,
    input  wire logic             tail,
    input  wire logic [W-1:0]     ld_a,
    input  wire logic [W-1:0]     ld_n,
    input  wire logic [W-1:0]     nb_a,
    input  wire logic [W-1:0]     nb_n,
    input  wire logic [W-1:0]     nb_t,
    input  wire logic [W-1:0]     hd_a,
    input  wire logic [W-1:0]     hd_n,
    input  wire logic [W-1:0]     new_t,
    output logic      [W-1:0]     a,
    output logic      [W-1:0]     n,
    output logic      [W-1:0]     t
);
    import mmc_pkg::*;

    logic [W-1:0] a_reg, a_next;
    logic [W-1:0] n_reg, n_next;
    logic [W-1:0] t_reg, t_next;

    always_comb
    begin
        a_next = a_reg;
        n_next = n_reg;
        t_next = t_reg;
        if (ctl.load && sel)
        begin
            a_next = ld_a;
            n_next = ld_n;
        end
        else if (ctl.rot_an)
        begin
            // the tail closes the ring onto cell 0
            a_next = tail ? hd_a : nb_a;
            n_next = tail ? hd_n : nb_n;
        end
        if (ctl.clear_t)
            t_next = '0;
        else if (ctl.rot_t)
            t_next = tail ? new_t : nb_t;
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        n_reg <= n_next;
        t_reg <= t_next;
    end

    assign a = a_reg;
    assign n = n_reg;
    assign t = t_reg;

endmodule
`default_nettype wire

@@ design/mmc_seq.sv @@
`default_nettype none
module mmc_seq #(
    parameter int MAX_LIMBS  = 32,
    parameter int LIMB_WIDTH = 32,
    parameter int CW = $clog2(MAX_LIMBS + 1),
    parameter int IW = (MAX_LIMBS > 1) ? $clog2(MAX_LIMBS) : 1
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [mmc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [mmc_pkg::CFG_DATA_W-1:0]  cfg_data,
    mmc_in_if.sink                               operands,
    mmc_out_if.source                            result,
    input  wire logic [LIMB_WIDTH-1:0]           head_a,
    input  wire logic [LIMB_WIDTH-1:0]           head_n,
    input  wire logic [LIMB_WIDTH-1:0]           head_t,
    output mmc_pkg::mmc_ctl_t                    ctl,
    output logic      [IW-1:0]                   load_idx,
    output logic      [CW-1:0]                   keff,
    output logic      [LIMB_WIDTH-1:0]           new_t
);
    import mmc_pkg::*;

    localparam int W    = LIMB_WIDTH;
    localparam int CW1  = CW + 1;
    localparam int CMPW = ((CW > LEN_W) ? CW : LEN_W) + 1;

    localparam logic [2:0] S_LOAD   = 3'd0;
    localparam logic [2:0] S_PREP   = 3'd1;
    localparam logic [2:0] S_PASS_A = 3'd2;
    localparam logic [2:0] S_FOLD_A = 3'd3;
    localparam logic [2:0] S_MUL_M  = 3'd4;
    localparam logic [2:0] S_PASS_N = 3'd5;
    localparam logic [2:0] S_FOLD_N = 3'd6;
    localparam logic [2:0] S_EMIT   = 3'd7;

    logic [LEN_W-1:0] lc_reg, a_len_reg, b_len_reg;
    logic [W-1:0]     ninv_reg;

    logic [2:0]       state_reg, state_next;
    logic [CW-1:0]    pos_reg, pos_next;
    logic [CW-1:0]    i_reg, i_next;
    logic [CW-1:0]    j_reg, j_next;
    logic [W-1:0]     carry_reg, carry_next;
    logic [W-1:0]     top0_reg, top0_next;
    logic [W-1:0]     top1_reg, top1_next;
    logic [W-1:0]     m_reg, m_next;
    logic [W-1:0]     bi_reg;
    logic [W-1:0]     b_mem [MAX_LIMBS];

    logic             out_valid_reg, out_valid_next;
    logic [W-1:0]     out_limb_reg, out_limb_next;
    logic             out_last_reg, out_last_next;

    logic             accept, start, slot_free, last_step;
    logic [CW-1:0]    k_m1;
    logic [W-1:0]     aj, mul_x, mul_y;
    logic [2*W-1:0]   prod, sum;
    logic [W:0]       fold;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lc_reg    <= LEN_W'(1);
            ninv_reg  <= '0;
            a_len_reg <= '0;
            b_len_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_LIMB_COUNT: lc_reg    <= cfg_data[LEN_W-1:0];
                REG_NEG_INV:    ninv_reg  <= cfg_data[W-1:0];
                REG_A_LENGTH:   a_len_reg <= cfg_data[LEN_W-1:0];
                REG_B_LENGTH:   b_len_reg <= cfg_data[LEN_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        if (lc_reg == '0)
            keff = CW'(1);
        else if (CMPW'(lc_reg) > CMPW'(MAX_LIMBS))
            keff = CW'(MAX_LIMBS);
        else
            keff = lc_reg[CW-1:0];
    end

    assign k_m1      = keff - CW'(1);
    assign accept    = operands.valid && operands.ready;
    assign start     = accept && (CW1'(pos_reg) + CW1'(1) >= CW1'(keff));
    assign slot_free = !out_valid_reg || result.ready;
    assign last_step = (j_reg == k_m1);
    assign load_idx  = pos_reg[IW-1:0];

    // one shared multiplier: a*b[i], T[0]*n0inv, m*n[j]
    assign aj = (CMPW'(j_reg) < CMPW'(a_len_reg)) ? head_a : '0;
    always_comb
    begin
        unique case (state_reg)
            S_PASS_A: begin mul_x = aj;     mul_y = bi_reg;   end
            S_MUL_M:  begin mul_x = head_t; mul_y = ninv_reg; end
            default:  begin mul_x = m_reg;  mul_y = head_n;   end
        endcase
    end
    assign prod = mul_x * mul_y;
    assign sum  = (2*W)'(head_t) + prod + (2*W)'(carry_reg);
    assign fold = (W+1)'(top0_reg) + (W+1)'(carry_reg);

    always_ff @(posedge clk)
    begin
        if (accept)
            b_mem[pos_reg[IW-1:0]] <= operands.b_limb;
        if (state_reg == S_PREP)
            bi_reg <= (CMPW'(i_reg) < CMPW'(b_len_reg)) ? b_mem[i_reg[IW-1:0]] : '0;
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        carry_next     = carry_reg;
        top0_next      = top0_reg;
        top1_next      = top1_reg;
        m_next         = m_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_limb_next  = out_limb_reg;
        out_last_next  = out_last_reg;
        ctl            = '0;
        new_t          = sum[W-1:0];

        unique case (state_reg)
            S_LOAD:
            begin
                ctl.load = accept;
                if (accept)
                begin
                    if (start)
                    begin
                        pos_next    = '0;
                        ctl.clear_t = 1'b1;
                        top0_next   = '0;
                        top1_next   = '0;
                        carry_next  = '0;
                        i_next      = '0;
                        state_next  = S_PREP;
                    end
                    else
                        pos_next = pos_reg + CW'(1);
                end
            end
            S_PREP:
            begin
                j_next     = '0;
                state_next = S_PASS_A;
            end
            S_PASS_A, S_PASS_N:
            begin
                ctl.rot_an = 1'b1;
                ctl.rot_t  = 1'b1;
                carry_next = sum[2*W-1:W];
                j_next     = j_reg + CW'(1);
                if (last_step)
                    state_next = (state_reg == S_PASS_A) ? S_FOLD_A : S_FOLD_N;
            end
            S_FOLD_A:
            begin
                top0_next  = fold[W-1:0];
                top1_next  = top1_reg + W'(fold[W]);
                carry_next = '0;
                state_next = S_MUL_M;
            end
            S_MUL_M:
            begin
                m_next     = prod[W-1:0];
                j_next     = '0;
                state_next = S_PASS_N;
            end
            S_FOLD_N:
            begin
                // fold and drop T[0]: the extra rotation shifts the ring down one limb
                ctl.rot_t  = 1'b1;
                new_t      = fold[W-1:0];
                top0_next  = top1_reg + W'(fold[W]);
                top1_next  = '0;
                carry_next = '0;
                i_next     = i_reg + CW'(1);
                j_next     = '0;
                state_next = (i_reg == k_m1) ? S_EMIT : S_PREP;
            end
            S_EMIT:
            begin
                new_t = head_t;
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    j_next         = j_reg + CW'(1);
                    if (j_reg == keff)
                    begin
                        out_limb_next = top0_reg;
                        out_last_next = 1'b1;
                        state_next    = S_LOAD;
                    end
                    else
                    begin
                        ctl.rot_t     = 1'b1;
                        out_limb_next = head_t;
                        out_last_next = 1'b0;
                    end
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            pos_reg       <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        carry_reg    <= carry_next;
        top0_reg     <= top0_next;
        top1_reg     <= top1_next;
        m_reg        <= m_next;
        out_limb_reg <= out_limb_next;
        out_last_reg <= out_last_next;
    end

    assign operands.ready     = (state_reg == S_LOAD);
    assign result.valid       = out_valid_reg;
    assign result.result_limb = out_limb_reg;
    assign result.last        = out_last_reg;

`ifndef SYNTHESIS
    a_pass_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PASS_A || state_reg == S_PASS_N) |-> j_reg < keff)
        else $error("limb index ran past k");

    a_round_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_LOAD && state_reg != S_EMIT) |-> i_reg < keff)
        else $error("round index ran past k");

    a_carry_clr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL_M || state_reg == S_PREP) |-> carry_reg == '0)
        else $error("carry not cleared between passes");

    a_last_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && slot_free && j_reg == keff)
        |=> (state_reg == S_LOAD && out_valid_reg && out_last_reg))
        else $error("final limb did not close the operation");
`endif

endmodule
`default_nettype wire

@@ design/montgomery_multiply_cios.sv @@
`default_nettype none
// CIOS Montgomery multiplier, T = a*b*R^-1 mod n with R = 2^(LIMB_WIDTH*k), no final
// subtraction. Each input beat carries limb j of a, b and n, least significant first;
// the k-th beat starts the product. Operand and modulus limbs sit in a ring of
// MAX_LIMBS cells that rotates one place per cycle during each pass past a single
// LIMB_WIDTH x LIMB_WIDTH multiply-accumulate unit, which sets the speed. Each of
// the k rounds runs a b-limb fetch, an a*b[i] pass, a fold, the m computation, an
// m*n pass and a fold with shift; the result then leaves as k+1 beats (last on
// limb k), which output stalls can hold. Input is taken only while loading, one
// beat per cycle, so a new load waits for the previous product's last result beat.
module montgomery_multiply_cios #(
    parameter int MAX_LIMBS  = 32,
    parameter int LIMB_WIDTH = 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [mmc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [mmc_pkg::CFG_DATA_W-1:0]  cfg_data,
    mmc_in_if.sink                               operands,
    mmc_out_if.source                            result
);
    import mmc_pkg::*;

    localparam int W  = LIMB_WIDTH;
    localparam int CW = $clog2(MAX_LIMBS + 1);
    localparam int IW = (MAX_LIMBS > 1) ? $clog2(MAX_LIMBS) : 1;

    mmc_ctl_t      ctl;
    logic [IW-1:0] load_idx;
    logic [CW-1:0] keff;
    logic [W-1:0]  new_t;
    logic [W-1:0]  a_q [MAX_LIMBS];
    logic [W-1:0]  n_q [MAX_LIMBS];
    logic [W-1:0]  t_q [MAX_LIMBS];

    mmc_seq #(
        .MAX_LIMBS  (MAX_LIMBS),
        .LIMB_WIDTH (LIMB_WIDTH),
        .CW         (CW),
        .IW         (IW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .operands  (operands),
        .result    (result),
        .head_a    (a_q[0]),
        .head_n    (n_q[0]),
        .head_t    (t_q[0]),
        .ctl       (ctl),
        .load_idx  (load_idx),
        .keff      (keff),
        .new_t     (new_t)
    );

    for (genvar c = 0; c < MAX_LIMBS; c++)
    begin : g_cell
        localparam int NB = (c < MAX_LIMBS - 1) ? c + 1 : 0;

        mmc_cell #(
            .W (W)
        ) u_cell (
            .clk   (clk),
            .ctl   (ctl),
            .sel   (load_idx == IW'(c)),
            .tail  (keff - CW'(1) == CW'(c)),
            .ld_a  (operands.a_limb),
            .ld_n  (operands.mod_limb),
            .nb_a  (a_q[NB]),
            .nb_n  (n_q[NB]),
            .nb_t  (t_q[NB]),
            .hd_a  (a_q[0]),
            .hd_n  (n_q[0]),
            .new_t (new_t),
            .a     (a_q[c]),
            .n     (n_q[c]),
            .t     (t_q[c])
        );
    end

endmodule
`default_nettype wire

@@ verif/tb_montgomery_multiply_cios.sv @@
`default_nettype none
module tb_montgomery_multiply_cios;
    timeunit 1ns;
    timeprecision 1ps;

    import mmc_pkg::*;

    localparam int MAX_LIMBS  = 32;
    localparam int LIMB_WIDTH = 32;
    localparam int TARGET_ITEMS = 470;
    localparam int QUIET_AFTER  = 400;
    localparam longint CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [31:0] limb;
        logic        last;
    } result_beat_t;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    mmc_in_if  #(.W(LIMB_WIDTH)) operands ();
    mmc_out_if #(.W(LIMB_WIDTH)) result ();

    montgomery_multiply_cios #(
        .MAX_LIMBS (MAX_LIMBS),
        .LIMB_WIDTH(LIMB_WIDTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .operands (operands),
        .result   (result)
    );

    // shadow of the block
    logic [5:0]  limb_count_q;
    logic [31:0] neg_inv_q;
    logic [5:0]  a_len_q;
    logic [5:0]  b_len_q;
    logic [31:0] a_mem [MAX_LIMBS];
    logic [31:0] b_mem [MAX_LIMBS];
    logic [31:0] n_mem [MAX_LIMBS];
    logic [31:0] acc [MAX_LIMBS+2];
    logic [5:0]  load_pos;

    result_beat_t pending_limbs[$];
    int items_sent;
    int products_done;
    int beats_checked;
    int mismatches;
    int extra_beats;
    bit quiet;
    longint cycles;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("montgomery_multiply_cios regression: fail");
                $finish;
            end
        end
    end

    function automatic int eff_k();
        if (limb_count_q == 0)
            return 1;
        if (limb_count_q > MAX_LIMBS)
            return MAX_LIMBS;
        return limb_count_q;
    endfunction

    function automatic void fold_top(int k, logic [63:0] carry);
        logic [63:0] top;
        top = {32'd0, acc[k]} + carry;
        acc[k] = top[31:0];
        acc[k+1] = acc[k+1] + top[63:32];
    endfunction

    function automatic void montgomery_product(int k);
        logic [63:0] s;
        logic [63:0] carry;
        logic [63:0] bi;
        logic [63:0] aj;
        logic [63:0] m_full;
        logic [31:0] m;
        for (int j = 0; j < MAX_LIMBS + 2; j++)
            acc[j] = '0;
        for (int i = 0; i < k; i++)
        begin
            bi = (i < b_len_q) ? {32'd0, b_mem[i]} : 64'd0;
            carry = 0;
            for (int j = 0; j < k; j++)
            begin
                aj = (j < a_len_q) ? {32'd0, a_mem[j]} : 64'd0;
                s = {32'd0, acc[j]} + aj * bi + carry;
                acc[j] = s[31:0];
                carry = s >> 32;
            end
            fold_top(k, carry);
            m_full = {32'd0, acc[0]} * {32'd0, neg_inv_q};
            m = m_full[31:0];
            carry = 0;
            for (int j = 0; j < k; j++)
            begin
                s = {32'd0, acc[j]} + {32'd0, m} * {32'd0, n_mem[j]} + carry;
                acc[j] = s[31:0];
                carry = s >> 32;
            end
            fold_top(k, carry);
            for (int j = 0; j <= k; j++)
                acc[j] = acc[j+1];
            acc[k+1] = '0;
        end
    endfunction

    // store one accepted beat; queue the product when the load completes
    function automatic void absorb_beat(logic [31:0] a, logic [31:0] b, logic [31:0] n);
        int k;
        result_beat_t beat;
        k = eff_k();
        if (load_pos < MAX_LIMBS)
        begin
            a_mem[load_pos] = a;
            b_mem[load_pos] = b;
            n_mem[load_pos] = n;
        end
        if (int'(load_pos) + 1 < k)
        begin
            load_pos = load_pos + 6'd1;
            return;
        end
        load_pos = 0;
        montgomery_product(k);
        products_done++;
        for (int j = 0; j <= k; j++)
        begin
            beat.limb = acc[j];
            beat.last = (j == k);
            pending_limbs.push_back(beat);
        end
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [5:0] value6, logic [31:0] value);
        logic [31:0] data;
        // narrow registers get junk in the upper bits
        data = (idx == REG_NEG_INV) ? value : {$urandom() & 32'hFFFF_FFC0} | value6;
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_LIMB_COUNT: limb_count_q = data[5:0];
            REG_NEG_INV:    neg_inv_q = data;
            REG_A_LENGTH:   a_len_q = data[5:0];
            REG_B_LENGTH:   b_len_q = data[5:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(int k, logic [31:0] ninv, int alen, int blen);
        write_reg(REG_LIMB_COUNT, k[5:0], 32'(k));
        write_reg(REG_NEG_INV, 6'd0, ninv);
        write_reg(REG_A_LENGTH, alen[5:0], 32'(alen));
        write_reg(REG_B_LENGTH, blen[5:0], 32'(blen));
    endtask

    // one beat; valid stays high unless a gap is drawn
    task automatic send_beat(logic [31:0] a, logic [31:0] b, logic [31:0] n);
        bit taken;
        operands.valid    <= 1'b1;
        operands.a_limb   <= a;
        operands.b_limb   <= b;
        operands.mod_limb <= n;
        do
        begin
            @(negedge clk);
            taken = operands.ready;
            @(posedge clk);
        end
        while (!taken);
        absorb_beat(a, b, n);
        items_sent++;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            operands.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic drop_valid();
        operands.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        while (pending_limbs.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [31:0] neg_inverse(logic [31:0] n0);
        logic [31:0] x;
        x = n0;
        repeat (5) x = x * (32'd2 - n0 * x);
        return -x;
    endfunction

    function automatic logic [31:0] rand_limb();
        case ($urandom_range(0, 7))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_product(int k, bit good_modulus);
        logic [31:0] n0;
        n0 = rand_limb() | (good_modulus ? 32'd1 : 32'd0);
        for (int j = 0; j < k; j++)
            send_beat(rand_limb(), rand_limb(), (j == 0) ? n0 : rand_limb());
        drop_valid();
    endtask

    // result side: random back-pressure, check on every accepted beat
    initial
    begin
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 7) == 0)
            begin
                result.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            result.ready <= 1'b1;
        end
    end

    initial
    begin
        result_beat_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n && result.valid && result.ready)
            begin
                if (pending_limbs.size() == 0)
                begin
                    extra_beats++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat limb=%h last=%b",
                                 result.result_limb, result.last);
                end
                else
                begin
                    want = pending_limbs.pop_front();
                    beats_checked++;
                    if (result.result_limb !== want.limb || result.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected limb=%h last=%b, got limb=%h last=%b",
                                     want.limb, want.last, result.result_limb, result.last);
                    end
                end
            end
        end
    end

    task automatic test_reset_defaults();
        // k=1, lengths 0: product is zero regardless of the limbs
        send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drop_valid();
        wait_idle();
    endtask

    task automatic test_single_limb_extremes();
        set_regs(1, neg_inverse(32'hFFFF_FFFF), 1, 1);
        send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drop_valid();
        wait_idle();
        write_reg(REG_NEG_INV, 6'd0, neg_inverse(32'd1));
        send_beat(32'd0, 32'hFFFF_FFFF, 32'd1);
        drop_valid();
        wait_idle();
    endtask

    task automatic test_zero_limb_count();
        // zero counts as one limb
        set_regs(0, neg_inverse(32'h1234_5677), 63, 63);
        send_beat(32'hDEAD_BEEF, 32'hCAFE_F00D, 32'h1234_5677);
        drop_valid();
        wait_idle();
    endtask

    task automatic test_operand_lengths();
        set_regs(3, neg_inverse(32'h8000_0001), 0, 3);
        send_product(3, 1);
        wait_idle();
        set_regs(3, neg_inverse(32'hFFFF_FFFF), 1, 32);
        send_product(3, 1);
        wait_idle();
        set_regs(3, 32'hFFFF_FFFF, 5, 2);
        send_product(3, 0);
        wait_idle();
    endtask

    task automatic test_shrink_midload();
        // lowering k below the load position fires on the next beat
        set_regs(5, neg_inverse(32'h0000_0003), 5, 5);
        for (int j = 0; j < 3; j++)
            send_beat(rand_limb(), rand_limb(), (j == 0) ? 32'd3 : rand_limb());
        drop_valid();
        repeat (20) @(posedge clk);
        write_reg(REG_LIMB_COUNT, 6'd2, 32'd2);
        send_beat(rand_limb(), rand_limb(), rand_limb());
        drop_valid();
        wait_idle();
    endtask

    task automatic test_random_products();
        int k;
        int roll;
        logic [31:0] n0;
        while (items_sent < TARGET_ITEMS)
        begin
            if (items_sent >= QUIET_AFTER)
                quiet = 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 3)
                k = $urandom_range(33, 63);
            else if (roll < 6)
                k = 32;
            else if (roll < 8)
                k = 0;
            else
                k = $urandom_range(1, 6);
            n0 = rand_limb() | 32'd1;
            set_regs(k, ($urandom_range(0, 9) == 0) ? $urandom() : neg_inverse(n0),
                     $urandom_range(0, 9) == 0 ? $urandom_range(0, 63) : $urandom_range(0, 32),
                     $urandom_range(0, 9) == 0 ? $urandom_range(0, 63) : $urandom_range(0, 32));
            k = eff_k();
            for (int j = 0; j < k; j++)
                send_beat(rand_limb(), rand_limb(),
                          (j == 0 && $urandom_range(0, 9) != 0) ? n0 : rand_limb());
            drop_valid();
            wait_idle();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        operands.valid = 1'b0;
        operands.a_limb = '0;
        operands.b_limb = '0;
        operands.mod_limb = '0;
        limb_count_q = 6'd1;
        neg_inv_q = '0;
        a_len_q = '0;
        b_len_q = '0;
        load_pos = '0;
        for (int j = 0; j < MAX_LIMBS; j++)
        begin
            a_mem[j] = '0;
            b_mem[j] = '0;
            n_mem[j] = '0;
        end
        items_sent = 0;
        products_done = 0;
        beats_checked = 0;
        mismatches = 0;
        extra_beats = 0;
        quiet = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_reset_defaults();
        test_single_limb_extremes();
        test_zero_limb_count();
        test_operand_lengths();
        test_shrink_midload();
        test_random_products();

        wait_idle();
        $display("covered %0d operand beats, %0d products, %0d result beats checked",
                 items_sent, products_done, beats_checked);
        $display("limb counts 0..63 incl. clamping, lengths 0..63, k lowered mid-load");
        if (mismatches == 0 && pending_limbs.size() == 0)
            $display("montgomery_multiply_cios regression: pass");
        else
        begin
            $display("%0d mismatches, %0d left over", mismatches, pending_limbs.size());
            $display("montgomery_multiply_cios regression: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire
